[hw/rtl/lcr_pkg.sv]
`default_nettype none

package lcr_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int SUM_W       = 32;
  localparam int COUNT_W     = 8;
  localparam int DIVISOR_W   = COUNT_W + 1;
  localparam int GAIN_W      = 2;
  localparam int TARE_W      = 24;
  localparam int WEIGHT_W    = 25;
  localparam int BIT_CNT_W   = 5;
  localparam int STEP_CNT_W  = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [BIT_CNT_W-1:0] SAMPLE_BITS = BIT_CNT_W'(SAMPLE_W);

  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PULSES   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARE_OFFSET   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DHIGH,
    PH_DLOW,
    PH_GHIGH,
    PH_GLOW,
    PH_DIV
  } phase_t;

  typedef struct packed {
    logic sample_clr;
    logic shift_en;
    logic accumulate;
    logic div_start;
    logic emit_tick;
    logic emit_result;
    logic sck;
  } ctrl_cmd_t;

  typedef struct packed {
    logic avg_done;
    logic div_busy;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/lcr_div.sv]
`default_nettype none

module lcr_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lcr_pkg::SUM_W-1:0]      dividend,
  input  wire logic [lcr_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                busy,
  output logic [lcr_pkg::SUM_W-1:0]           quotient
);

  logic [lcr_pkg::STEP_CNT_W-1:0] step_cnt;
  logic [lcr_pkg::DIVISOR_W-1:0]  rem;
  logic [lcr_pkg::DIVISOR_W-1:0]  dvs;
  logic [lcr_pkg::SUM_W-1:0]      quo;
  logic                           neg;

  logic [lcr_pkg::SUM_W-1:0]      magnitude;
  logic [lcr_pkg::DIVISOR_W:0]    trial;
  logic [lcr_pkg::DIVISOR_W:0]    trial_diff;
  logic                           fits;

  assign magnitude  = dividend[lcr_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial      = {rem, quo[lcr_pkg::SUM_W-1]};
  assign trial_diff = trial - {1'b0, dvs};
  assign fits       = (trial >= {1'b0, dvs});
  assign quotient   = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      step_cnt <= '0;
    end else if (busy) begin
      step_cnt <= step_cnt + 1'b1;
      if (step_cnt == '1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= magnitude;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[lcr_pkg::SUM_W-1];
    end else if (busy) begin
      quo <= {quo[lcr_pkg::SUM_W-2:0], fits};
      rem <= fits ? trial_diff[lcr_pkg::DIVISOR_W-1:0] : trial[lcr_pkg::DIVISOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lcr_dpath.sv]
`default_nettype none

module lcr_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lcr_pkg::ctrl_cmd_t            cmd,
  input  wire logic                          dout_level,
  input  wire logic [lcr_pkg::COUNT_W-1:0]   average_count,
  input  wire logic [lcr_pkg::TARE_W-1:0]    tare_offset,
  input  wire logic                          out_ready,
  output lcr_pkg::dp_status_t                status,
  output logic                               out_valid,
  output logic                               out_sck,
  output logic                               out_result_valid,
  output logic [lcr_pkg::WEIGHT_W-1:0]       out_weight
);

  logic [lcr_pkg::SAMPLE_W-1:0] sample;
  logic [lcr_pkg::SUM_W-1:0]    sum_acc;
  logic [lcr_pkg::COUNT_W-1:0]  reads_done;

  logic [lcr_pkg::COUNT_W-1:0]  reads_inc;
  logic [lcr_pkg::COUNT_W-1:0]  count_eff;
  logic [lcr_pkg::SUM_W-1:0]    sum_new;
  logic [lcr_pkg::SUM_W-1:0]    quotient;
  logic                         div_busy;
  logic [lcr_pkg::SUM_W:0]      diff;

  assign reads_inc = reads_done + 1'b1;
  assign count_eff = (average_count == '0) ? lcr_pkg::COUNT_W'(1) : average_count;
  assign sum_new   = sum_acc
                   + {{(lcr_pkg::SUM_W-lcr_pkg::SAMPLE_W){sample[lcr_pkg::SAMPLE_W-1]}}, sample};
  assign diff      = {quotient[lcr_pkg::SUM_W-1], quotient}
                   - {{(lcr_pkg::SUM_W+1-lcr_pkg::TARE_W){tare_offset[lcr_pkg::TARE_W-1]}},
                      tare_offset};

  assign status.avg_done  = (reads_inc == '0) || (reads_inc >= count_eff);
  assign status.div_busy  = div_busy;
  assign status.slot_free = !out_valid || out_ready;

  lcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_new),
    .divisor  ({reads_inc == '0, reads_inc}),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.sample_clr) begin
      sample <= '0;
    end else if (cmd.shift_en) begin
      sample <= {sample[lcr_pkg::SAMPLE_W-2:0], dout_level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc    <= '0;
      reads_done <= '0;
    end else if (cmd.accumulate) begin
      if (status.avg_done) begin
        sum_acc    <= '0;
        reads_done <= '0;
      end else begin
        sum_acc    <= sum_new;
        reads_done <= reads_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_tick || cmd.emit_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_result) begin
      out_sck          <= 1'b0;
      out_result_valid <= 1'b1;
      out_weight       <= diff[lcr_pkg::WEIGHT_W-1:0];
    end else if (cmd.emit_tick) begin
      out_sck          <= cmd.sck;
      out_result_valid <= 1'b0;
      out_weight       <= '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lcr_ctrl.sv]
`default_nettype none

module lcr_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         dout_level,
  input  wire logic [lcr_pkg::GAIN_W-1:0]   gain_pulses,
  input  wire lcr_pkg::dp_status_t          status,
  output logic                              in_ready,
  output lcr_pkg::ctrl_cmd_t                cmd
);

  lcr_pkg::phase_t                 state;
  lcr_pkg::phase_t                 state_next;
  logic [lcr_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [lcr_pkg::BIT_CNT_W-1:0]   bit_cnt_next;
  logic [lcr_pkg::GAIN_W-1:0]      pulse_cnt;
  logic [lcr_pkg::GAIN_W-1:0]      pulse_cnt_next;

  logic [lcr_pkg::GAIN_W-1:0]      pulses_eff;
  logic                            gain_done;
  logic                            fire;

  assign pulses_eff = (gain_pulses == '0) ? lcr_pkg::GAIN_W'(1) : gain_pulses;
  assign gain_done  = (pulse_cnt >= pulses_eff) || (pulse_cnt == '0);
  assign in_ready   = !rst && (state != lcr_pkg::PH_DIV) && status.slot_free;
  assign fire       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcr_pkg::PH_IDLE;
      bit_cnt   <= '0;
      pulse_cnt <= '0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      pulse_cnt <= pulse_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    pulse_cnt_next = pulse_cnt;
    case (state)
      lcr_pkg::PH_IDLE: begin
        if (fire && !dout_level) begin
          state_next     = lcr_pkg::PH_DHIGH;
          bit_cnt_next   = '0;
          pulse_cnt_next = '0;
        end
      end
      lcr_pkg::PH_DHIGH: begin
        if (fire) begin
          bit_cnt_next = bit_cnt + 1'b1;
          state_next   = lcr_pkg::PH_DLOW;
        end
      end
      lcr_pkg::PH_DLOW: begin
        if (fire) begin
          if (bit_cnt >= lcr_pkg::SAMPLE_BITS) begin
            pulse_cnt_next = '0;
            state_next     = lcr_pkg::PH_GHIGH;
          end else begin
            state_next = lcr_pkg::PH_DHIGH;
          end
        end
      end
      lcr_pkg::PH_GHIGH: begin
        if (fire) begin
          pulse_cnt_next = pulse_cnt + 1'b1;
          state_next     = lcr_pkg::PH_GLOW;
        end
      end
      lcr_pkg::PH_GLOW: begin
        if (fire) begin
          if (gain_done) begin
            bit_cnt_next   = '0;
            pulse_cnt_next = '0;
            state_next     = status.avg_done ? lcr_pkg::PH_DIV : lcr_pkg::PH_IDLE;
          end else begin
            state_next = lcr_pkg::PH_GHIGH;
          end
        end
      end
      lcr_pkg::PH_DIV: begin
        if (!status.div_busy && status.slot_free) begin
          state_next = lcr_pkg::PH_IDLE;
        end
      end
      default: begin
        state_next = lcr_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      lcr_pkg::PH_IDLE: begin
        cmd.emit_tick  = fire;
        cmd.sample_clr = fire && !dout_level;
      end
      lcr_pkg::PH_DHIGH: begin
        cmd.emit_tick = fire;
        cmd.shift_en  = fire;
        cmd.sck       = 1'b1;
      end
      lcr_pkg::PH_DLOW: begin
        cmd.emit_tick = fire;
      end
      lcr_pkg::PH_GHIGH: begin
        cmd.emit_tick = fire;
        cmd.sck       = 1'b1;
      end
      lcr_pkg::PH_GLOW: begin
        if (fire) begin
          if (gain_done) begin
            cmd.accumulate = 1'b1;
            cmd.div_start  = status.avg_done;
            cmd.emit_tick  = !status.avg_done;
          end else begin
            cmd.emit_tick = 1'b1;
          end
        end
      end
      lcr_pkg::PH_DIV: begin
        cmd.emit_result = !status.div_busy && status.slot_free;
      end
      default: begin
        cmd.emit_tick = fire;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/load_cell_adc_serial_reader.sv]
// Output: the result of a tick is registered and offered in the cycle after the tick is taken;
// for a tick that completes an average the divider runs first, and the registered result is
// offered once the divider is done and the output slot is free. Input: one tick per cycle while
// the output slot is free; after a tick that completes an average, no tick is taken until the
// restoring divider (one quotient bit per cycle) is done. Reset: synchronous and active high;
// registers return to gain 1, count 1, tare 0, and the reader waits idle.
`default_nettype none

module load_cell_adc_serial_reader (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [lcr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] dout_level
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [lcr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // [0] sck_level, [25:1] weight_value
  output logic                                   m_axis_tuser,  // [0] result_valid
  input  wire logic                              cfg_we,
  input  wire logic [lcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [lcr_pkg::GAIN_W-1:0]   gain_pulses;
  logic [lcr_pkg::COUNT_W-1:0]  average_count;
  logic [lcr_pkg::TARE_W-1:0]   tare_offset;

  lcr_pkg::ctrl_cmd_t           cmd;
  lcr_pkg::dp_status_t          status;
  logic                         out_sck;
  logic                         out_result_valid;
  logic [lcr_pkg::WEIGHT_W-1:0] out_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_pulses   <= lcr_pkg::GAIN_W'(1);
      average_count <= lcr_pkg::COUNT_W'(1);
      tare_offset   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcr_pkg::CFG_GAIN_PULSES:   gain_pulses   <= cfg_data[lcr_pkg::GAIN_W-1:0];
        lcr_pkg::CFG_AVERAGE_COUNT: average_count <= cfg_data[lcr_pkg::COUNT_W-1:0];
        lcr_pkg::CFG_TARE_OFFSET:   tare_offset   <= cfg_data[lcr_pkg::TARE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lcr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .dout_level  (s_axis_tdata[0]),
    .gain_pulses (gain_pulses),
    .status      (status),
    .in_ready    (s_axis_tready),
    .cmd         (cmd)
  );

  lcr_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .dout_level       (s_axis_tdata[0]),
    .average_count    (average_count),
    .tare_offset      (tare_offset),
    .out_ready        (m_axis_tready),
    .status           (status),
    .out_valid        (m_axis_tvalid),
    .out_sck          (out_sck),
    .out_result_valid (out_result_valid),
    .out_weight       (out_weight)
  );

  assign m_axis_tdata = {{(lcr_pkg::OUT_TDATA_W-lcr_pkg::WEIGHT_W-1){1'b0}}, out_weight, out_sck};
  assign m_axis_tuser = out_result_valid;

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tdata[0])
    else $error("Averaged result offered with the serial clock high.");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[25:1] == '0))
    else $error("Weight not zero on a tick without a result.");

  assert property (@(posedge clk) disable iff (rst)
    status.div_busy |-> !s_axis_tready)
    else $error("Input taken while the divider is running.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("Divider failed to start.");
`endif

endmodule

`default_nettype wire
